[rtl/flpc_pkg.sv]
// Shared constants, types and the coefficient table of the low-pass/comb PWM unit.
package flpc_pkg;

   localparam int TAPS     = 11;
   localparam int TAP_W    = $clog2(TAPS);
   localparam int CNT_W    = $clog2(TAPS + 2);
   localparam int SAMPLE_W = 15;
   localparam int WORD_W   = 16;
   localparam int DUTY_W   = 11;
   localparam int COEF_W   = 14;
   localparam int ACC_W    = 32;
   localparam int PROD_W   = WORD_W + COEF_W;
   localparam int FRAC_W   = 16;
   localparam int HI_W     = ACC_W - 1 - FRAC_W;
   localparam int SCALE_W  = 13;
   localparam int LPP_W    = HI_W + SCALE_W;
   localparam int X_W      = WORD_W + 1;
   localparam int CMBP_W   = X_W + COEF_W;

   localparam logic signed [ACC_W-1:0] LP_OFFSET = 32'sd628924032;
   localparam logic signed [ACC_W-1:0] LP_ROUND  = 32'sh0000_8000;
   localparam logic signed [ACC_W-1:0] LP_BIAS   = LP_OFFSET + LP_ROUND;
   localparam logic [SCALE_W-1:0]      LP_SCALE  = 13'h13AC;
   localparam logic signed [X_W-1:0]   COMB_OFFSET = 17'sd16368;
   localparam logic signed [COEF_W-1:0] COMB_SCALE = 14'sd2953;
   localparam logic [DUTY_W-1:0]       DUTY_MAX  = 11'd1475;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MAC   = 4'b0010,
      ST_SCALE = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   // Read data tag, aligned with the RAM output.
   typedef struct packed {
      logic             vld;
      logic [TAP_W-1:0] tap;
      logic             live;
   } rd_type;

   typedef struct packed {
      logic start;
      logic scale;
   } ctl_type;

   function automatic logic signed [COEF_W-1:0] coef(input logic [TAP_W-1:0] tap);
      logic signed [COEF_W-1:0] c;
      case (tap)
         4'd1, 4'd9: c = 14'sd1534;
         4'd2, 4'd8: c = 14'sd3306;
         4'd3, 4'd7: c = 14'sd4961;
         4'd4, 4'd6: c = 14'sd6134;
         4'd5:       c = 14'sd6554;
         default:    c = '0;
      endcase
      return c;
   endfunction

endpackage

[rtl/flpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module flpc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/flpc_ctrl.sv]
// Sequencer: ring pointer, entry valid bits, tap reads and the item state machine.
module flpc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       out_free,
   output logic                       wr_en,
   output logic [flpc_pkg::TAP_W-1:0] wr_addr,
   output logic                       rd_en,
   output logic [flpc_pkg::TAP_W-1:0] rd_addr,
   output flpc_pkg::rd_type           rd,
   output flpc_pkg::ctl_type          ctl,
   output logic                       emit
);

   flpc_pkg::state_type state_ff, state_in;
   logic [flpc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [flpc_pkg::TAP_W-1:0] wptr_ff, wptr_in;
   logic [flpc_pkg::TAPS-1:0]  vld_ff, vld_in;
   flpc_pkg::rd_type           rd_ff, rd_in;
   logic                       accept;
   logic [flpc_pkg::TAP_W-1:0] tap;
   logic [flpc_pkg::TAP_W-1:0] wptr_next;

   assign req_stall = (state_ff != flpc_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign wptr_next = (wptr_ff == flpc_pkg::TAP_W'(flpc_pkg::TAPS - 1)) ? '0 : wptr_ff + 1'b1;
   assign wr_en     = accept;
   assign wr_addr   = wptr_next;
   assign tap       = cnt_ff[flpc_pkg::TAP_W-1:0];
   assign rd_en     = (state_ff == flpc_pkg::ST_MAC)
                      && (cnt_ff < flpc_pkg::CNT_W'(flpc_pkg::TAPS));
   // Position k of the line sits k entries behind the newest one, modulo the ring size.
   assign rd_addr   = (wptr_ff >= tap) ? wptr_ff - tap
                      : wptr_ff + flpc_pkg::TAP_W'(flpc_pkg::TAPS) - tap;
   assign emit      = (state_ff == flpc_pkg::ST_EMIT) && out_free;
   assign rd        = rd_ff;
   assign ctl.start = accept;
   assign ctl.scale = (state_ff == flpc_pkg::ST_SCALE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      wptr_in  = wptr_ff;
      vld_in   = vld_ff;
      unique case (state_ff)
         flpc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in         = flpc_pkg::ST_MAC;
               cnt_in           = '0;
               wptr_in          = wptr_next;
               vld_in[wptr_next] = 1'b1;
            end
         end
         flpc_pkg::ST_MAC: begin
            cnt_in = cnt_ff + 1'b1;
            // last product lands in the accumulator at this edge
            if (cnt_ff == flpc_pkg::CNT_W'(flpc_pkg::TAPS + 1)) begin
               state_in = flpc_pkg::ST_SCALE;
            end
         end
         flpc_pkg::ST_SCALE: begin
            state_in = flpc_pkg::ST_EMIT;
         end
         flpc_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = flpc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = flpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rd_in.vld  = rd_en;
      rd_in.tap  = tap;
      rd_in.live = vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= flpc_pkg::ST_IDLE;
         cnt_ff   <= '0;
         wptr_ff  <= flpc_pkg::TAP_W'(flpc_pkg::TAPS - 1);
         vld_ff   <= '0;
         rd_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         wptr_ff  <= wptr_in;
         vld_ff   <= vld_in;
         rd_ff    <= rd_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_starts_mac: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == flpc_pkg::ST_MAC) && (cnt_ff == '0))
      else $error("accepted transaction did not start the tap sweep");

   a_mac_to_scale: assert property (@(posedge clock) disable iff (reset)
      (state_ff == flpc_pkg::ST_MAC) && (cnt_ff == flpc_pkg::CNT_W'(flpc_pkg::TAPS + 1))
      |=> (state_ff == flpc_pkg::ST_SCALE))
      else $error("tap sweep did not hand over to scaling");

   a_no_write_during_read: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !wr_en)
      else $error("delay line written during tap reads");

   a_wptr_in_range: assert property (@(posedge clock) disable iff (reset)
      wptr_ff < flpc_pkg::TAP_W'(flpc_pkg::TAPS))
      else $error("ring pointer out of range");
`endif

endmodule

[rtl/flpc_dp.sv]
// Datapath: multiply-accumulate over the taps, comb average, output scaling and clamps.
module flpc_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  flpc_pkg::rd_type                   rd,
   input  logic signed [flpc_pkg::WORD_W-1:0] rd_data,
   input  flpc_pkg::ctl_type                  ctl,
   output logic [flpc_pkg::DUTY_W-1:0]        lowpass_duty,
   output logic [flpc_pkg::DUTY_W-1:0]        comb_duty
);

   logic signed [flpc_pkg::WORD_W-1:0] tap_val;
   logic signed [flpc_pkg::COEF_W-1:0] coef_val;
   logic signed [flpc_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                               prod_vld_ff;
   logic signed [flpc_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [flpc_pkg::WORD_W-1:0] newest_ff;
   logic signed [flpc_pkg::X_W-1:0]    pair_sum;
   logic signed [flpc_pkg::X_W-1:0]    comb_x_ff, comb_x_in;
   logic                               lp_neg_ff;
   logic [flpc_pkg::LPP_W-1:0]         lp_prod_ff;
   logic signed [flpc_pkg::CMBP_W-1:0] comb_prod_ff;
   logic [flpc_pkg::LPP_W-flpc_pkg::FRAC_W-1:0]         lp_q;
   logic signed [flpc_pkg::CMBP_W-flpc_pkg::FRAC_W-1:0] comb_q;

   // Entries never written since reset read as zero.
   assign tap_val  = rd.live ? rd_data : '0;
   assign coef_val = flpc_pkg::coef(rd.tap);
   assign prod_in  = flpc_pkg::PROD_W'(tap_val) * flpc_pkg::PROD_W'(coef_val);
   assign acc_in   = ctl.start ? flpc_pkg::LP_BIAS
                     : prod_vld_ff ? acc_ff + flpc_pkg::ACC_W'(prod_ff) : acc_ff;
   assign pair_sum  = flpc_pkg::X_W'(newest_ff) + flpc_pkg::X_W'(tap_val);
   assign comb_x_in = (pair_sum >>> 1) + flpc_pkg::COMB_OFFSET;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= rd.vld;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (rd.vld && (rd.tap == '0)) begin
         newest_ff <= tap_val;
      end
      if (rd.vld && (rd.tap == flpc_pkg::TAP_W'(flpc_pkg::TAPS - 1))) begin
         comb_x_ff <= comb_x_in;
      end
      if (ctl.scale) begin
         lp_neg_ff    <= acc_ff[flpc_pkg::ACC_W-1];
         lp_prod_ff   <= flpc_pkg::LPP_W'(acc_ff[flpc_pkg::ACC_W-2:flpc_pkg::FRAC_W])
                         * flpc_pkg::LPP_W'(flpc_pkg::LP_SCALE);
         comb_prod_ff <= flpc_pkg::CMBP_W'(comb_x_ff) * flpc_pkg::CMBP_W'(flpc_pkg::COMB_SCALE);
      end
   end

   assign lp_q   = lp_prod_ff[flpc_pkg::LPP_W-1:flpc_pkg::FRAC_W];
   assign comb_q = comb_prod_ff[flpc_pkg::CMBP_W-1:flpc_pkg::FRAC_W];

   // Saturate both paths to the PWM compare range.
   always_comb begin
      if (lp_neg_ff) begin
         lowpass_duty = '0;
      end else if (lp_q > flpc_pkg::DUTY_MAX) begin
         lowpass_duty = flpc_pkg::DUTY_MAX;
      end else begin
         lowpass_duty = lp_q[flpc_pkg::DUTY_W-1:0];
      end
      if (comb_q < 0) begin
         comb_duty = '0;
      end else if (comb_q > $signed({1'b0, flpc_pkg::DUTY_MAX})) begin
         comb_duty = flpc_pkg::DUTY_MAX;
      end else begin
         comb_duty = comb_q[flpc_pkg::DUTY_W-1:0];
      end
   end

endmodule

[rtl/fir_lowpass_comb_pwm_unit.sv]
// Top level of the 11-tap low-pass and comb filter unit with PWM compare outputs.
//
// Usage:
//   req_valid/req_stall carry one signed 15-bit sample per transaction.
//   rsp_valid/rsp_stall carry one result: rsp_lowpass_duty and rsp_comb_duty,
//   both PWM compare values clamped to 0..1475.
//   The 11 most recent samples live in an 11-entry ring RAM; one shared
//   multiplier walks the taps, one tap per cycle.
// Sequence: after a sample is accepted, the unit makes the 11 tap reads,
//   drains the two-stage multiply-accumulate, scales the result, and loads
//   it into the output register once that register is free.
// Flow: one sample at a time, set by the single RAM read port and the
//   shared multiply-accumulate. req_stall is high while an item is
//   being processed.
// Reset: synchronous, active high; the delay line reads as all zeros
//   (per-entry valid bits), and no result is pending.
// Stall: a result held by rsp_stall stays stable in the output register; the
//   next sample is still accepted and processed, and waits for the register.
module fir_lowpass_comb_pwm_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [flpc_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [flpc_pkg::DUTY_W-1:0]          rsp_lowpass_duty,
   output logic [flpc_pkg::DUTY_W-1:0]          rsp_comb_duty
);

   logic                       wr_en;
   logic [flpc_pkg::TAP_W-1:0] wr_addr;
   logic                       rd_en;
   logic [flpc_pkg::TAP_W-1:0] rd_addr;
   logic [flpc_pkg::WORD_W-1:0] rd_data;
   flpc_pkg::rd_type           rd;
   flpc_pkg::ctl_type          ctl;
   logic                       emit;
   logic                       out_free;
   logic [flpc_pkg::DUTY_W-1:0] lowpass_duty;
   logic [flpc_pkg::DUTY_W-1:0] comb_duty;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [flpc_pkg::DUTY_W-1:0] lowpass_ff;
   logic [flpc_pkg::DUTY_W-1:0] comb_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   flpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd        (rd),
      .ctl       (ctl),
      .emit      (emit)
   );

   flpc_ram #(
      .WIDTH (flpc_pkg::WORD_W),
      .DEPTH (flpc_pkg::TAPS)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (flpc_pkg::WORD_W'(req_sample)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   flpc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .rd           (rd),
      .rd_data      (rd_data),
      .ctl          (ctl),
      .lowpass_duty (lowpass_duty),
      .comb_duty    (comb_duty)
   );

   // Hold the result until the receiver takes it; drop valid once taken.
   assign rsp_valid_in = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         lowpass_ff <= lowpass_duty;
         comb_ff    <= comb_duty;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lowpass_duty = lowpass_ff;
   assign rsp_comb_duty    = comb_ff;

endmodule
